FILE: rtl/catmull_rom_keyframe_interp_unit_assert.svh
// Assertion macros shared by the keyframe interpolator RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef CATMULL_ROM_KEYFRAME_INTERP_UNIT_ASSERT_SVH
`define CATMULL_ROM_KEYFRAME_INTERP_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CRKI_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define CRKI_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define CRKI_ASSERT(label, clk, rst, prop)
`define CRKI_NEVER(label, clk, rst, cond)
`endif
`endif

FILE: rtl/crki_pkg.sv
// Shared constants, types and arithmetic helpers of the keyframe interpolator.
// No dependencies.
package crki_pkg;
   localparam int MAX_KEYS    = 16;
   localparam int IDX_W       = $clog2(MAX_KEYS);
   localparam int CNT_W       = 5;
   localparam int COORD_W     = 32;
   localparam int POS_W       = 18;
   localparam int FRAC_W      = 16;
   localparam int ACC_W       = 40;
   localparam int PROD_W      = ACC_W + FRAC_W + 1;
   localparam int LANES       = 3;
   localparam int TAPS        = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef enum logic [1:0] {
      METH_CLAMP  = 2'd0,
      METH_LINEAR = 2'd1,
      METH_CATROM = 2'd2
   } method_type;

   typedef logic signed [ACC_W-1:0] acc_type;

   // One decoded beat between front and back.
   typedef struct packed {
      logic                        is_write;
      logic [IDX_W-1:0]            base;
      logic signed [COORD_W-1:0]   z;
      logic signed [COORD_W-1:0]   y;
      logic signed [COORD_W-1:0]   x;
      method_type                  method;
      logic [FRAC_W-1:0]           frac;
   } entry_type;

   // rnd(r * f / 2^16) + add, rounding half up
   function automatic acc_type mac_rnd(input acc_type r, input logic [FRAC_W-1:0] f,
                                       input acc_type add);
      logic signed [PROD_W-1:0] prod;
      logic signed [PROD_W-1:0] rounded;
      prod    = r * $signed({1'b0, f});
      rounded = (prod + PROD_W'(32768)) >>> FRAC_W;
      return acc_type'(rounded[ACC_W-1:0]) + add;
   endfunction
endpackage

FILE: rtl/crki_front.sv
// Front end: key count register, item decode and segment classification.
// Depends on crki_pkg.
module crki_front import crki_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CNT_W-1:0]          csr_key_count,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   input  logic signed [POS_W-1:0]   req_key_position,
   output entry_type                 entry
);
   logic [CNT_W-1:0]              key_count_ff;
   logic [CNT_W-1:0]              key_count_in;
   logic [CNT_W-1:0]              n_eff;
   logic [CNT_W-1:0]              n_m1;
   logic signed [POS_W+CNT_W:0]   k;
   logic signed [CNT_W+2:0]       seg;
   logic signed [CNT_W+2:0]       n_s;

   assign csr_ready    = 1'b1;
   assign key_count_in = (csr_valid && csr_ready) ? csr_key_count : key_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= CNT_W'(1);
      end else begin
         key_count_ff <= key_count_in;
      end
   end

   always_comb begin
      if (key_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (key_count_ff > CNT_W'(MAX_KEYS)) begin
         n_eff = CNT_W'(MAX_KEYS);
      end else begin
         n_eff = key_count_ff;
      end
      n_m1 = n_eff - CNT_W'(1);
      k    = req_key_position * $signed({1'b0, n_m1});
      seg  = k[POS_W+CNT_W:FRAC_W];
      n_s  = $signed({3'b000, n_eff});

      entry.is_write = (req_mode == MODE_WRITE);
      entry.x        = req_point_x;
      entry.y        = req_point_y;
      entry.z        = req_point_z;
      entry.frac     = k[FRAC_W-1:0];
      if (req_mode == MODE_WRITE) begin
         entry.method = METH_CLAMP;
         entry.base   = req_entry_index;
      end else if (seg < 0) begin
         entry.method = METH_CLAMP;
         entry.base   = '0;
      end else if (seg >= n_s - 1) begin
         entry.method = METH_CLAMP;
         entry.base   = n_m1[IDX_W-1:0];
      end else if (seg > 0 && seg < n_s - 2 && n_eff >= CNT_W'(4)) begin
         entry.method = METH_CATROM;
         entry.base   = IDX_W'(seg - 1);
      end else begin
         entry.method = METH_LINEAR;
         entry.base   = seg[IDX_W-1:0];
      end
   end
endmodule

FILE: rtl/crki_queue.sv
// Short FIFO of decoded beats that decouples front from back.
// Depends on crki_pkg and the assertion macro header.
`include "catmull_rom_keyframe_interp_unit_assert.svh"
module crki_queue import crki_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type pop_entry,
   output logic      not_empty,
   output logic      not_full
);
   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CRKI_ASSERT(a_count_bound, clock, reset, count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
   `CRKI_NEVER(a_pop_empty, clock, reset, pop && !not_empty)
   `CRKI_NEVER(a_push_full, clock, reset, push && !pop && !not_full)
endmodule

FILE: rtl/crki_back.sv
// Back end: point table banks, coefficient stage, three Horner steps, output.
// Depends on crki_pkg and the assertion macro header.
`include "catmull_rom_keyframe_interp_unit_assert.svh"
module crki_back import crki_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  entry_type                 q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [1:0]                rsp_method_used
);
   localparam int ROW_W = LANES * COORD_W;

   logic                adv;
   logic [ROW_W-1:0]    bank_ff [TAPS][MAX_KEYS];
   logic [IDX_W-1:0]    rd_addr [TAPS];
   logic [ROW_W-1:0]    rd_data_ff [TAPS];

   logic                v1_ff, v1_in;
   method_type          meth1_ff;
   logic [FRAC_W-1:0]   frac1_ff;

   logic                v2_ff;
   method_type          meth2_ff;
   logic [FRAC_W-1:0]   frac2_ff;
   acc_type             d2_ff [LANES], d2_in [LANES];
   acc_type             c2_ff [LANES], c2_in [LANES];
   acc_type             b2_ff [LANES], b2_in [LANES];
   acc_type             a2_ff [LANES], a2_in [LANES];

   logic                v3_ff;
   method_type          meth3_ff;
   logic [FRAC_W-1:0]   frac3_ff;
   acc_type             r3_ff [LANES], r3_in [LANES];
   acc_type             b3_ff [LANES];
   acc_type             a3_ff [LANES];

   logic                v4_ff;
   method_type          meth4_ff;
   logic [FRAC_W-1:0]   frac4_ff;
   acc_type             r4_ff [LANES], r4_in [LANES];
   acc_type             a4_ff [LANES];

   logic                vo_ff;
   method_type          metho_ff;
   logic [COORD_W-1:0]  out_ff [LANES], out_in [LANES];

   assign adv   = !vo_ff || rsp_ready;
   assign q_pop = q_valid && adv;
   assign v1_in = q_pop && !q_entry.is_write;

   // Table: one bank per tap, all written together, each read at base + tap.
   always_comb begin
      for (int m = 0; m < TAPS; m++) begin
         rd_addr[m] = q_entry.base + IDX_W'(m);
      end
   end

   always_ff @(posedge clock) begin
      for (int m = 0; m < TAPS; m++) begin
         if (q_pop && q_entry.is_write) begin
            bank_ff[m][q_entry.base] <= {q_entry.z, q_entry.y, q_entry.x};
         end
         if (adv) begin
            rd_data_ff[m] <= bank_ff[m][rd_addr[m]];
         end
      end
   end

   // Coefficients; linear and clamp are folded into the same Horner chain.
   always_comb begin
      acc_type q0, q1, q2, q3;
      for (int l = 0; l < LANES; l++) begin
         q0 = ACC_W'($signed(rd_data_ff[0][l*COORD_W +: COORD_W]));
         q1 = ACC_W'($signed(rd_data_ff[1][l*COORD_W +: COORD_W]));
         q2 = ACC_W'($signed(rd_data_ff[2][l*COORD_W +: COORD_W]));
         q3 = ACC_W'($signed(rd_data_ff[3][l*COORD_W +: COORD_W]));
         case (meth1_ff)
            METH_CATROM: begin
               d2_in[l] = q1 * ACC_W'(3) - q0 - q2 * ACC_W'(3) + q3;
               c2_in[l] = (q0 <<< 1) - q1 * ACC_W'(5) + (q2 <<< 2) - q3;
               b2_in[l] = q2 - q0;
               a2_in[l] = q1 <<< 1;
            end
            METH_LINEAR: begin
               d2_in[l] = '0;
               c2_in[l] = '0;
               b2_in[l] = q1 - q0;
               a2_in[l] = q0;
            end
            default: begin
               d2_in[l] = '0;
               c2_in[l] = '0;
               b2_in[l] = '0;
               a2_in[l] = q0;
            end
         endcase
      end
   end

   always_comb begin
      acc_type h;
      for (int l = 0; l < LANES; l++) begin
         r3_in[l] = mac_rnd(d2_ff[l], frac2_ff, c2_ff[l]);
         r4_in[l] = mac_rnd(r3_ff[l], frac3_ff, b3_ff[l]);
         h        = mac_rnd(r4_ff[l], frac4_ff, a4_ff[l]);
         if (meth4_ff == METH_CATROM) begin
            h = (h + ACC_W'(1)) >>> 1;
         end
         if (h > ACC_W'(32'sh7fffffff)) begin
            out_in[l] = 32'h7fffffff;
         end else if (h < -ACC_W'(64'sh80000000)) begin
            out_in[l] = 32'h80000000;
         end else begin
            out_in[l] = h[COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meth1_ff <= q_entry.method;
         frac1_ff <= q_entry.frac;
         meth2_ff <= meth1_ff;
         frac2_ff <= frac1_ff;
         meth3_ff <= meth2_ff;
         frac3_ff <= frac2_ff;
         meth4_ff <= meth3_ff;
         frac4_ff <= frac3_ff;
         metho_ff <= meth4_ff;
         for (int l = 0; l < LANES; l++) begin
            d2_ff[l]  <= d2_in[l];
            c2_ff[l]  <= c2_in[l];
            b2_ff[l]  <= b2_in[l];
            a2_ff[l]  <= a2_in[l];
            r3_ff[l]  <= r3_in[l];
            b3_ff[l]  <= b2_ff[l];
            a3_ff[l]  <= a2_ff[l];
            r4_ff[l]  <= r4_in[l];
            a4_ff[l]  <= a3_ff[l];
            out_ff[l] <= out_in[l];
         end
      end
   end

   assign rsp_valid       = vo_ff;
   assign rsp_out_x       = out_ff[0];
   assign rsp_out_y       = out_ff[1];
   assign rsp_out_z       = out_ff[2];
   assign rsp_method_used = metho_ff;

   `CRKI_ASSERT(a_clamp_no_terms, clock, reset,
      (v2_ff && meth2_ff == METH_CLAMP) |-> (d2_ff[0] == '0 && b2_ff[0] == '0))
   `CRKI_ASSERT(a_write_no_result, clock, reset, (q_pop && q_entry.is_write) |=> !v1_ff)
   `CRKI_ASSERT(a_stall_holds, clock, reset, (v1_ff && !adv) |=> v1_ff)
endmodule

FILE: rtl/catmull_rom_keyframe_interp_unit.sv
// Top level of the 3D keyframe interpolator: front decode, beat queue, back pipeline.
// Depends on crki_pkg, crki_front, crki_queue and crki_back.
//
// Catmull-Rom keyframe interpolator. Load up to 16 key points with write beats
// (req_mode 0, slot in req_entry_index, Q16.16 coordinates), set the number of
// points in use with a beat on the csr_ channel while the block is idle, then
// send evaluate beats (req_mode 1) carrying a Q2.16 key position, where 0..1
// spans the table. Each evaluate beat yields one rsp_ beat in order; write beats
// yield none. Positions below the table return the first point, positions at or
// past the end of the table return the last point (method 0); edge segments and
// tables with fewer than four points interpolate linearly (method 1); inner
// segments use uniform Catmull-Rom (method 2). Results saturate to Q16.16.
// Only read slots that were written. Throughput is one beat per cycle while the
// response side does not stall; an evaluate result passes through the queue
// write, the table read, the coefficient stage and two Horner multiply stages,
// with the third Horner step and saturation feeding the output register. A
// four-entry beat queue lets the request side keep going while a result waits
// on rsp_ready.
module catmull_rom_keyframe_interp_unit import crki_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CNT_W-1:0]          csr_key_count,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_mode,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic signed [COORD_W-1:0] req_point_z,
   input  logic signed [POS_W-1:0]   req_key_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_out_x,
   output logic signed [COORD_W-1:0] rsp_out_y,
   output logic signed [COORD_W-1:0] rsp_out_z,
   output logic [1:0]                rsp_method_used
);
   entry_type front_entry;
   entry_type queue_entry;
   logic      queue_not_empty;
   logic      queue_not_full;
   logic      queue_pop;

   // Accept a request beat whenever the queue has room.
   assign req_ready = queue_not_full;

   crki_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_key_count    (csr_key_count),
      .req_mode         (req_mode),
      .req_entry_index  (req_entry_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .req_key_position (req_key_position),
      .entry            (front_entry)
   );

   // Writes travel the queue too, so table updates stay in order with reads.
   crki_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && req_ready),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .pop_entry  (queue_entry),
      .not_empty  (queue_not_empty),
      .not_full   (queue_not_full)
   );

   crki_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (queue_not_empty),
      .q_entry         (queue_entry),
      .q_pop           (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_method_used (rsp_method_used)
   );
endmodule
